// ===== sv/qbs_pkg.sv =====
// ----------------------------------------------------------------------------
// qbs_pkg
// Shared constants and types for the queue of bounded stacks unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qbs_pkg;

    // sizing of the stack ring and of the item store
    localparam int MAX_STACKS = 16;
    localparam int MAX_HEIGHT = 16;
    localparam int SLOT_W     = $clog2(MAX_STACKS);
    localparam int FILL_W     = $clog2(MAX_HEIGHT + 1);
    localparam int CNT_W      = $clog2(MAX_STACKS + 1);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = SLOT_W + ROW_W;
    localparam int DEPTH      = MAX_STACKS * MAX_HEIGHT;

    // field widths
    localparam int LIM_W  = 5;
    localparam int DEST_W = 16;
    localparam int VAL_W  = 32;
    localparam int ITEM_W = DEST_W + VAL_W;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register indexes
    localparam logic REG_STACK_LIMIT  = 1'b0;
    localparam logic REG_HEIGHT_LIMIT = 1'b1;

    // operation codes
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_SHIP  = 1'b1;

    // clamped limits from the register block
    typedef struct packed {
        logic [LIM_W-1:0] stack_lim;
        logic [LIM_W-1:0] height_lim;
    } qbs_lim_t;

    // one access to the item store
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [ITEM_W-1:0] wdata;
    } qbs_mem_req_t;

    // status of one step
    typedef struct packed {
        logic done;
        logic ship_ok;
        logic is_empty;
        logic is_full;
    } qbs_flags_t;

endpackage

`default_nettype wire

// ===== sv/qbs_cfg.sv =====
// ----------------------------------------------------------------------------
// qbs_cfg
// Limit registers behind the APB-style port, with clamping of the limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qbs_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [qbs_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [qbs_pkg::PDATA_W-1:0]  pwdata,
    output logic      [qbs_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output qbs_pkg::qbs_lim_t                 lim
);
    import qbs_pkg::*;

    logic [LIM_W-1:0] stack_limit_reg;
    logic [LIM_W-1:0] height_limit_reg;
    logic             wr_fire;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_limit_reg  <= LIM_W'(MAX_STACKS);
            height_limit_reg <= LIM_W'(MAX_HEIGHT);
        end
        else if (wr_fire)
        begin
            case (reg_sel)
                REG_STACK_LIMIT:  stack_limit_reg  <= pwdata[LIM_W-1:0];
                REG_HEIGHT_LIMIT: height_limit_reg <= pwdata[LIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_sel)
            REG_STACK_LIMIT:  prdata = {{(PDATA_W-LIM_W){1'b0}}, stack_limit_reg};
            REG_HEIGHT_LIMIT: prdata = {{(PDATA_W-LIM_W){1'b0}}, height_limit_reg};
            default:          prdata = '0;
        endcase
    end

    // clamp to 1..max, zero acts as one
    always_comb
    begin
        if (stack_limit_reg == '0)
            lim.stack_lim = LIM_W'(1);
        else if (stack_limit_reg > LIM_W'(MAX_STACKS))
            lim.stack_lim = LIM_W'(MAX_STACKS);
        else
            lim.stack_lim = stack_limit_reg;

        if (height_limit_reg == '0)
            lim.height_lim = LIM_W'(1);
        else if (height_limit_reg > LIM_W'(MAX_HEIGHT))
            lim.height_lim = LIM_W'(MAX_HEIGHT);
        else
            lim.height_lim = height_limit_reg;
    end

endmodule

`default_nettype wire

// ===== sv/qbs_item_store.sv =====
// ----------------------------------------------------------------------------
// qbs_item_store
// Item memory, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qbs_item_store (
    input  wire logic                        clk,
    input  wire qbs_pkg::qbs_mem_req_t       req,
    output logic     [qbs_pkg::ITEM_W-1:0]   rd_data
);
    import qbs_pkg::*;

    logic [ITEM_W-1:0] mem [DEPTH];
    logic [ITEM_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.addr] <= req.wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
            rd_data_reg <= mem[req.addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/qbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// qbs_ctrl
// Stack ring pointers and per-stack fill counts, one step per accepted item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qbs_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic                        op,
    input  wire logic [qbs_pkg::ITEM_W-1:0]  item,
    input  wire qbs_pkg::qbs_lim_t           lim,
    output qbs_pkg::qbs_mem_req_t            req,
    output qbs_pkg::qbs_flags_t              flags
);
    import qbs_pkg::*;

    // fill counts held in queue order: entry 0 is the front stack
    logic [FILL_W-1:0] fill_reg   [MAX_STACKS];
    logic [FILL_W-1:0] fill_next  [MAX_STACKS];
    logic [SLOT_W-1:0] front_reg;
    logic [SLOT_W-1:0] front_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [SLOT_W-1:0] back_pos;
    logic [FILL_W-1:0] back_fill;
    logic              back_full;
    logic              open_new;
    logic [SLOT_W-1:0] push_pos;
    logic [FILL_W-1:0] push_fill;
    logic [FILL_W-1:0] front_fill;
    logic [SLOT_W-1:0] back_pos_next;

    assign back_pos  = count_reg[SLOT_W-1:0] - SLOT_W'(1);
    assign back_fill = fill_reg[back_pos];

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STACKS; i++)
                fill_reg[i] <= '0;
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < MAX_STACKS; i++)
                fill_reg[i] <= fill_next[i];
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // step logic
    always_comb
    begin
        for (int i = 0; i < MAX_STACKS; i++)
            fill_next[i] = fill_reg[i];
        front_next    = front_reg;
        count_next    = count_reg;
        req.wr_en     = 1'b0;
        req.rd_en     = 1'b0;
        req.addr      = '0;
        req.wdata     = item;
        flags.done    = 1'b0;
        flags.ship_ok = 1'b0;
        back_full     = (count_reg != '0) && (back_fill >= lim.height_lim);
        open_new      = (count_reg == '0) ||
                        (back_full && (count_reg < CNT_W'(lim.stack_lim)));
        push_pos      = back_pos;
        push_fill     = back_fill;
        front_fill    = fill_reg[0];

        if (accept)
        begin
            case (op)
                OP_STORE:
                begin
                    // open a fresh back stack where allowed
                    if (open_new)
                    begin
                        push_pos   = count_reg[SLOT_W-1:0];
                        push_fill  = '0;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (push_fill < lim.height_lim)
                    begin
                        req.wr_en           = 1'b1;
                        req.addr            = {front_reg + push_pos, push_fill[ROW_W-1:0]};
                        fill_next[push_pos] = push_fill + FILL_W'(1);
                        flags.done          = 1'b1;
                    end
                end
                OP_SHIP:
                begin
                    if (count_reg != '0)
                    begin
                        // pop the top of the front stack
                        if (fill_reg[0] != '0)
                        begin
                            front_fill    = fill_reg[0] - FILL_W'(1);
                            req.rd_en     = 1'b1;
                            req.addr      = {front_reg, front_fill[ROW_W-1:0]};
                            flags.done    = 1'b1;
                            flags.ship_ok = 1'b1;
                            fill_next[0]  = front_fill;
                        end
                        // drop an emptied front stack
                        if (front_fill == '0)
                        begin
                            front_next = front_reg + SLOT_W'(1);
                            count_next = count_reg - CNT_W'(1);
                            for (int i = 0; i < MAX_STACKS - 1; i++)
                                fill_next[i] = fill_reg[i+1];
                            fill_next[MAX_STACKS-1] = '0;
                        end
                    end
                end
                default: ;
            endcase
        end

        // flags after the step
        back_pos_next  = count_next[SLOT_W-1:0] - SLOT_W'(1);
        flags.is_empty = (count_next == '0);
        flags.is_full  = (count_next != '0) &&
                         (count_next >= CNT_W'(lim.stack_lim)) &&
                         (fill_next[back_pos_next] >= lim.height_lim);
    end

    // every open stack holds at least one item, so the front is never empty
    a_front_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (fill_reg[0] != '0))
        else $error("open front stack with no items");

    // a refused ship from an empty queue leaves the ring alone
    a_empty_ship_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_SHIP) && (count_reg == '0))
            |=> ($stable(front_reg) && (count_reg == '0)))
        else $error("ship from empty queue moved the ring");

    // a store never lowers the stack count
    a_store_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_STORE)) |=> (count_reg >= $past(count_reg)))
        else $error("store lowered the stack count");

    // a write and a read never share a cycle
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr_en && req.rd_en))
        else $error("item store written and read together");

endmodule

`default_nettype wire

// ===== sv/queue_of_bounded_stacks_unit.sv =====
// ----------------------------------------------------------------------------
// queue_of_bounded_stacks_unit
// FIFO of bounded stacks of items: store pushes on the back stack, ship pops
// the front stack.
// ----------------------------------------------------------------------------
//  channel   ports                                      handshake
//  -------   -----------------------------------------  ------------------------
//  command   op, item_destination, item_value           start && !busy
//  result    done_res, out_destination, out_value,      strobe, one cycle
//            is_empty, is_full
//  config    psel, penable, pwrite, paddr, pwdata,      psel && penable && pwrite
//            prdata, pready
//
//  one item per cycle; busy stays low, so an item may be started every cycle
//  the result of an item appears in the cycle after it is started, for one cycle
//  the result registers line up with the registered read port of the item store
//  reset is asynchronous and active low and empties the queue at once
//  the receiver cannot stall, so nothing holds the result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module queue_of_bounded_stacks_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         op,
    input  wire logic [qbs_pkg::DEST_W-1:0]   item_destination,
    input  wire logic [qbs_pkg::VAL_W-1:0]    item_value,
    output logic                              strobe,
    output logic                              done_res,
    output logic      [qbs_pkg::DEST_W-1:0]   out_destination,
    output logic      [qbs_pkg::VAL_W-1:0]    out_value,
    output logic                              is_empty,
    output logic                              is_full,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [qbs_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [qbs_pkg::PDATA_W-1:0]  pwdata,
    output logic      [qbs_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);
    import qbs_pkg::*;

    qbs_lim_t          lim;
    qbs_mem_req_t      req;
    qbs_flags_t        flags;
    qbs_flags_t        flags_reg;
    logic              strobe_reg;
    logic              accept;
    logic [ITEM_W-1:0] rd_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // limit registers
    qbs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .lim     (lim)
    );

    // ring control
    qbs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .op     (op),
        .item   ({item_destination, item_value}),
        .lim    (lim),
        .req    (req),
        .flags  (flags)
    );

    // item memory
    qbs_item_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            flags_reg  <= '0;
        end
        else
        begin
            strobe_reg <= accept;
            if (accept)
                flags_reg <= flags;
        end
    end

    // result outputs, item data only after a successful ship
    assign strobe          = strobe_reg;
    assign done_res        = flags_reg.done;
    assign is_empty        = flags_reg.is_empty;
    assign is_full         = flags_reg.is_full;
    assign out_destination = flags_reg.ship_ok ? rd_data[ITEM_W-1:VAL_W] : '0;
    assign out_value       = flags_reg.ship_ok ? rd_data[VAL_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== bench/queue_of_bounded_stacks_unit_tb.sv =====
// ----------------------------------------------------------------------------
// queue_of_bounded_stacks_unit_tb
// Self-checking bench for the queue of bounded stacks. Directed items cover
// the field extremes, refused ships and stores, full queues, limits out of
// range and limits lowered under open stacks. Random phases follow under many
// limit settings. Every result is checked against a local model of the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module queue_of_bounded_stacks_unit_tb;

    import qbs_pkg::*;

    // one expected result
    typedef struct packed {
        logic              done;
        logic [DEST_W-1:0] dest;
        logic [VAL_W-1:0]  val;
        logic              empty;
        logic              full;
    } route_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               op = OP_STORE;
    logic [DEST_W-1:0]  item_destination = '0;
    logic [VAL_W-1:0]   item_value = '0;
    logic               strobe;
    logic               done_res;
    logic [DEST_W-1:0]  out_destination;
    logic [VAL_W-1:0]   out_value;
    logic               is_empty;
    logic               is_full;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // local copy of the queue
    logic [ITEM_W-1:0]  shelf [DEPTH];
    int                 slot_fill [MAX_STACKS] = '{default: 0};
    int                 front_idx = 0;
    int                 stacks_open = 0;
    logic [LIM_W-1:0]   stack_lim_reg = 5'd16;
    logic [LIM_W-1:0]   height_lim_reg = 5'd16;

    route_result_t      awaited_results [$];
    int                 mismatch_count = 0;
    bit                 steady_stream = 1'b0;

    queue_of_bounded_stacks_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .item_destination (item_destination),
        .item_value       (item_value),
        .strobe           (strobe),
        .done_res         (done_res),
        .out_destination  (out_destination),
        .out_value        (out_value),
        .is_empty         (is_empty),
        .is_full          (is_full),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // hard stop
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string note);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t ns: %s", $realtime, note);
    endtask

    // register value clamped into 1..top
    function automatic int clamp_lim(input logic [LIM_W-1:0] r, input int top);
        if (r < 1)
            return 1;
        if (r > top)
            return top;
        return int'(r);
    endfunction

    function automatic int back_slot_idx();
        return (front_idx + stacks_open + MAX_STACKS - 1) % MAX_STACKS;
    endfunction

    // work out the result of one accepted item and queue it
    task automatic predict_dispatch(input logic cmd, input logic [DEST_W-1:0] dest,
                                    input logic [VAL_W-1:0] val);
        int            lim_s;
        int            lim_h;
        int            b;
        int            f;
        route_result_t r;
        lim_s = clamp_lim(stack_lim_reg, MAX_STACKS);
        lim_h = clamp_lim(height_lim_reg, MAX_HEIGHT);
        r = '0;
        if (cmd == OP_STORE)
        begin
            // open a new back stack when empty, or when the back one is full and the stack limit allows
            if (stacks_open == 0 || (slot_fill[back_slot_idx()] >= lim_h &&
                                     stacks_open < lim_s))
            begin
                stacks_open++;
                slot_fill[back_slot_idx()] = 0;
            end
            b = back_slot_idx();
            if (slot_fill[b] < lim_h)
            begin
                shelf[b * MAX_HEIGHT + slot_fill[b]] = {dest, val};
                slot_fill[b]++;
                r.done = 1'b1;
            end
        end
        else if (stacks_open != 0)
        begin
            f = front_idx;
            if (slot_fill[f] != 0)
            begin
                slot_fill[f]--;
                {r.dest, r.val} = shelf[f * MAX_HEIGHT + slot_fill[f]];
                r.done = 1'b1;
            end
            // drop the front stack once emptied
            if (slot_fill[f] == 0)
            begin
                front_idx = (f + 1) % MAX_STACKS;
                stacks_open--;
            end
        end
        r.empty = (stacks_open == 0);
        r.full  = (stacks_open != 0 && stacks_open >= lim_s &&
                   slot_fill[back_slot_idx()] >= lim_h);
        awaited_results.push_back(r);
    endtask

    // offer one item and hold it until it is taken
    task automatic send_item(input logic cmd, input logic [DEST_W-1:0] dest,
                             input logic [VAL_W-1:0] val);
        start            <= 1'b1;
        op               <= cmd;
        item_destination <= dest;
        item_value       <= val;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_dispatch(cmd, dest, val);
    endtask

    // random gap on the command side, mostly short
    task automatic pause_sender();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (steady_stream || pick < 55)
            return;
        n = (pick < 90) ? $urandom_range(1, 3) : $urandom_range(4, 24);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    // write both limit registers back to back, only while idle
    task automatic set_limits(input logic [LIM_W-1:0] s, input logic [LIM_W-1:0] h);
        logic [PDATA_W-1:0] noise;
        logic [LIM_W-1:0]   v;
        logic               idx;
        for (int i = 0; i < 2; i++)
        begin
            idx   = (i == 0) ? REG_STACK_LIMIT : REG_HEIGHT_LIMIT;
            v     = (i == 0) ? s : h;
            noise = $urandom;
            psel    <= 1'b1;
            pwrite  <= 1'b1;
            penable <= 1'b0;
            paddr   <= {idx, 2'b00};
            pwdata  <= {noise[PDATA_W-1:LIM_W], v};
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (pready !== 1'b1);
            if (idx == REG_STACK_LIMIT)
                stack_lim_reg = v;
            else
                height_lim_reg = v;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one random item, store biased by fill_pct
    task automatic random_item(input int fill_pct);
        logic              cmd;
        logic [DEST_W-1:0] dest;
        logic [VAL_W-1:0]  val;
        cmd = ($urandom_range(0, 99) < fill_pct) ? OP_STORE : OP_SHIP;
        case ($urandom_range(0, 7))
            0:       dest = '0;
            1:       dest = '1;
            default: dest = DEST_W'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 7))
            0:       val = '0;
            1:       val = '1;
            default: val = $urandom;
        endcase
        send_item(cmd, dest, val);
        pause_sender();
    endtask

    // first half leans one way, second half the other
    task automatic random_phase(input int n, input int fill_pct);
        steady_stream = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
            random_item((i < n / 2) ? fill_pct : 100 - fill_pct);
        steady_stream = 1'b0;
    endtask

    // ship from an empty queue is refused
    task automatic test_empty_ship();
        send_item(OP_SHIP, '0, '0);
        send_item(OP_SHIP, '1, '1);
    endtask

    // field extremes come back in reverse order
    task automatic test_extreme_fields();
        send_item(OP_STORE, '0, '0);
        send_item(OP_STORE, '1, '1);
        send_item(OP_STORE, 16'h5555, 32'hAAAA_AAAA);
        send_item(OP_STORE, 16'hAAAA, 32'h5555_5555);
        repeat (4) send_item(OP_SHIP, DEST_W'($urandom_range(0, 65535)), $urandom);
    endtask

    // single short stack: refused store when full, refill after a ship
    task automatic test_full_queue();
        drain_results();
        set_limits(5'd1, 5'd2);
        repeat (3) send_item(OP_STORE, DEST_W'($urandom_range(0, 65535)), $urandom);
        send_item(OP_SHIP, '0, '0);
        send_item(OP_STORE, DEST_W'($urandom_range(0, 65535)), $urandom);
        repeat (2) send_item(OP_SHIP, '0, '0);
    endtask

    // zero limits act as one
    task automatic test_out_of_range_limits();
        drain_results();
        set_limits(5'd0, 5'd0);
        repeat (2) send_item(OP_STORE, DEST_W'($urandom_range(0, 65535)), $urandom);
        send_item(OP_SHIP, '0, '0);
    endtask

    // limits lowered under an open stack keep its items
    task automatic test_lowered_limits();
        drain_results();
        set_limits(5'd16, 5'd16);
        repeat (3) send_item(OP_STORE, DEST_W'($urandom_range(0, 65535)), $urandom);
        drain_results();
        set_limits(5'd2, 5'd1);
        repeat (2) send_item(OP_STORE, DEST_W'($urandom_range(0, 65535)), $urandom);
    endtask

    // random phases under many limit settings
    task automatic test_random();
        logic [LIM_W-1:0] s;
        logic [LIM_W-1:0] h;
        // store-heavy then ship-heavy phase under the clamped top limits
        drain_results();
        set_limits(5'd31, 5'd31);
        random_phase(300, 95);
        drain_results();
        set_limits(5'd16, 5'd16);
        random_phase(140, 8);
        for (int k = 0; k < 9; k++)
        begin
            if (k == 0)
            begin
                s = 5'd1;
                h = 5'd1;
            end
            else if (k == 1)
            begin
                s = 5'd31;
                h = 5'd0;
            end
            else if (k % 3 == 0)
            begin
                s = LIM_W'($urandom_range(0, 31));
                h = LIM_W'($urandom_range(0, 31));
            end
            else
            begin
                s = LIM_W'($urandom_range(1, 5));
                h = LIM_W'($urandom_range(1, 6));
            end
            drain_results();
            set_limits(s, h);
            random_phase(50, 80);
        end
    endtask

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        route_result_t want;
        if (rst_n && strobe === 1'b1)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = awaited_results.pop_front();
                if (done_res !== want.done)
                    report_mismatch($sformatf("done_res got %0h expected %0h",
                                              done_res, want.done));
                if (out_destination !== want.dest)
                    report_mismatch($sformatf("out_destination got %0h expected %0h",
                                              out_destination, want.dest));
                if (out_value !== want.val)
                    report_mismatch($sformatf("out_value got %0h expected %0h",
                                              out_value, want.val));
                if (is_empty !== want.empty)
                    report_mismatch($sformatf("is_empty got %0h expected %0h",
                                              is_empty, want.empty));
                if (is_full !== want.full)
                    report_mismatch($sformatf("is_full got %0h expected %0h",
                                              is_full, want.full));
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_ship();
        test_extreme_fields();
        test_full_queue();
        test_out_of_range_limits();
        test_lowered_limits();
        test_random();
        drain_results();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/qbs_pkg.sv
sv/qbs_cfg.sv
sv/qbs_item_store.sv
sv/qbs_ctrl.sv
sv/queue_of_bounded_stacks_unit.sv
bench/queue_of_bounded_stacks_unit_tb.sv
